// ----- hw/rtl/xbr_pkg.sv -----
// Shared types, constants and CRC helper for the XMODEM block receiver.
package xbr_pkg;

  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] EOT_BYTE = 8'h04;
  localparam logic [7:0] CAN_BYTE = 8'h18;

  localparam int unsigned SMALL_LEN = 128;
  localparam int unsigned LARGE_LEN = 1024;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  typedef logic [10:0] pos_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_NEW       = 3'd1,
    KIND_DUPLICATE = 3'd2,
    KIND_OUT_OF_SEQ = 3'd3,
    KIND_BAD       = 3'd4,
    KIND_EOT       = 3'd5,
    KIND_CANCEL    = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    OP_START,
    OP_SEQ,
    OP_COMP,
    OP_PAYLOAD,
    OP_FIRST_TRAILER,
    OP_SUM_END,
    OP_CRC_END,
    OP_EOT,
    OP_CANCEL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       big;
  } entry_t;

  // CRC-16, poly 0x1021, MSB first, one byte per call.
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/xbr_front.sv -----
// Front end: tracks the framing position and classifies each line byte.
module xbr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  input  logic           cfg_data,
  input  logic           in_accept,
  input  logic [7:0]     rx_byte,
  input  logic           line_error,
  output logic           push,
  output xbr_pkg::entry_t push_entry
);
  import xbr_pkg::*;

  localparam pos_t SMALL_LAST = pos_t'(SMALL_LEN + 2);
  localparam pos_t LARGE_LAST = pos_t'(LARGE_LEN + 2);

  logic crc_mode;
  pos_t byte_position, byte_position_next;
  logic big_block, big_block_next;
  logic cancel_seen, cancel_seen_next;

  pos_t pos;
  pos_t last_payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode      <= 1'b1;
      byte_position <= '0;
      big_block     <= 1'b0;
      cancel_seen   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        crc_mode <= cfg_data;
      end
      byte_position <= byte_position_next;
      big_block     <= big_block_next;
      cancel_seen   <= cancel_seen_next;
    end
  end

  always_comb begin
    byte_position_next = byte_position;
    big_block_next     = big_block;
    cancel_seen_next   = cancel_seen;
    push               = 1'b0;
    push_entry.op      = OP_START;
    push_entry.data    = rx_byte;
    push_entry.big     = big_block;

    // a line error drops any partial block before this byte
    pos          = line_error ? '0 : byte_position;
    last_payload = big_block ? LARGE_LAST : SMALL_LAST;

    if (in_accept) begin
      if (pos == '0) begin
        case (rx_byte)
          SOH_BYTE, STX_BYTE: begin
            big_block_next     = (rx_byte == STX_BYTE);
            byte_position_next = pos_t'(1);
            push               = 1'b1;
            push_entry.op      = OP_START;
          end
          EOT_BYTE: begin
            byte_position_next = '0;
            push               = 1'b1;
            push_entry.op      = OP_EOT;
          end
          CAN_BYTE: begin
            byte_position_next = '0;
            if (cancel_seen) begin
              push          = 1'b1;
              push_entry.op = OP_CANCEL;
            end else begin
              cancel_seen_next = 1'b1;
            end
          end
          default: begin
            byte_position_next = '0;
            cancel_seen_next   = 1'b0;
          end
        endcase
      end else if (pos == pos_t'(1)) begin
        byte_position_next = pos_t'(2);
        push               = 1'b1;
        push_entry.op      = OP_SEQ;
      end else if (pos == pos_t'(2)) begin
        byte_position_next = pos_t'(3);
        push               = 1'b1;
        push_entry.op      = OP_COMP;
      end else if (pos <= last_payload) begin
        byte_position_next = pos + pos_t'(1);
        push               = 1'b1;
        push_entry.op      = OP_PAYLOAD;
      end else if (pos == last_payload + pos_t'(1)) begin
        push = 1'b1;
        if (!crc_mode) begin
          byte_position_next = '0;
          cancel_seen_next   = 1'b0;
          push_entry.op      = OP_SUM_END;
        end else begin
          byte_position_next = pos + pos_t'(1);
          push_entry.op      = OP_FIRST_TRAILER;
        end
      end else begin
        byte_position_next = '0;
        cancel_seen_next   = 1'b0;
        push               = 1'b1;
        push_entry.op      = OP_CRC_END;
      end
    end
  end

endmodule

// ----- hw/rtl/xbr_queue.sv -----
// Small register FIFO between the classifier and the block checker.
module xbr_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  xbr_pkg::entry_t push_entry,
  output logic            full,
  output logic            head_valid,
  output xbr_pkg::entry_t head_entry,
  input  logic            pop
);
  import xbr_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  logic do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/xbr_back.sv -----
// Back end: running checksum/CRC, sequence check, verdict and output register.
module xbr_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  xbr_pkg::entry_t head_entry,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      kind,
  output logic [7:0]      payload_byte,
  output logic [7:0]      block_number,
  output logic            large_block
);
  import xbr_pkg::*;

  logic [7:0]  seq_byte;
  logic [7:0]  seq_complement;
  logic [7:0]  running_sum;
  logic [15:0] running_crc;
  logic [7:0]  first_trailer_byte;
  logic [7:0]  expected_seq;

  logic        step;
  logic        emit;
  logic        trailer_ok;
  kind_t       verdict_kind;
  kind_t       emit_kind;
  logic [7:0]  emit_payload;
  logic [7:0]  emit_number;
  logic        emit_large;

  assign step = head_valid && (!out_valid || out_ready);
  assign pop  = step;

  always_comb begin
    if (head_entry.op == OP_SUM_END) begin
      trailer_ok = (head_entry.data == running_sum);
    end else begin
      trailer_ok = (first_trailer_byte == running_crc[15:8]) &&
                   (head_entry.data == running_crc[7:0]);
    end

    if ((seq_byte != ~seq_complement) || !trailer_ok) begin
      verdict_kind = KIND_BAD;
    end else if (seq_byte == expected_seq) begin
      verdict_kind = KIND_NEW;
    end else if (seq_byte == expected_seq - 8'd1) begin
      verdict_kind = KIND_DUPLICATE;
    end else begin
      verdict_kind = KIND_OUT_OF_SEQ;
    end

    emit         = 1'b0;
    emit_kind    = KIND_PAYLOAD;
    emit_payload = 8'h00;
    emit_number  = 8'h00;
    emit_large   = 1'b0;
    case (head_entry.op)
      OP_PAYLOAD: begin
        emit         = 1'b1;
        emit_payload = head_entry.data;
        emit_large   = head_entry.big;
      end
      OP_SUM_END, OP_CRC_END: begin
        emit        = 1'b1;
        emit_kind   = verdict_kind;
        emit_number = seq_byte;
        emit_large  = head_entry.big;
      end
      OP_EOT: begin
        emit      = 1'b1;
        emit_kind = KIND_EOT;
      end
      OP_CANCEL: begin
        emit      = 1'b1;
        emit_kind = KIND_CANCEL;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_byte           <= '0;
      seq_complement     <= '0;
      running_sum        <= '0;
      running_crc        <= '0;
      first_trailer_byte <= '0;
      expected_seq       <= 8'd1;
      out_valid          <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= emit;
        case (head_entry.op)
          OP_START: begin
            running_sum <= '0;
            running_crc <= '0;
          end
          OP_SEQ:           seq_byte           <= head_entry.data;
          OP_COMP:          seq_complement     <= head_entry.data;
          OP_FIRST_TRAILER: first_trailer_byte <= head_entry.data;
          OP_PAYLOAD: begin
            running_sum <= running_sum + head_entry.data;
            running_crc <= crc_update(running_crc, head_entry.data);
          end
          OP_SUM_END, OP_CRC_END: begin
            if (verdict_kind == KIND_NEW) begin
              expected_seq <= expected_seq + 8'd1;
            end
          end
          default: begin
          end
        endcase
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      kind         <= emit_kind;
      payload_byte <= emit_payload;
      block_number <= emit_number;
      large_block  <= emit_large;
    end
  end

endmodule

// ----- hw/rtl/xmodem_block_receiver.sv -----
// XMODEM / XMODEM-1K block receiver top level.
//
// Takes one line byte per transaction and can accept a byte every clock cycle
// while the FIFO is not full. A front classifier tracks the framing position
// (header, sequence byte, complement, payload, trailer) and pushes classified
// bytes into a small FIFO of QUEUE_DEPTH entries; the back end keeps the running
// 8-bit sum and CRC-16 (one full byte update per cycle while the output is not
// stalled, which sets the clock-rate path), checks the sequence pair and issues
// the verdict. Each result is registered into the output register from the FIFO
// head; input and output stall independently until the FIFO fills. The crc_mode
// register (reset 1 = CRC-16 trailer, 0 = checksum) is written through the cfg
// channel, which is always ready, and must only be changed while idle.
module xmodem_block_receiver #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       line_error,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] payload_byte,
  output logic [7:0] block_number,
  output logic       large_block
);
  import xbr_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   head_valid;
  entry_t head_entry;
  logic   pop;
  logic   in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  xbr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_accept  (in_accept),
    .rx_byte    (rx_byte),
    .line_error (line_error),
    .push       (push),
    .push_entry (push_entry)
  );

  xbr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  xbr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_entry   (head_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .block_number (block_number),
    .large_block  (large_block)
  );

endmodule

// ----- verif/xmodem_block_receiver_test.sv -----
// Self-checking testbench for the XMODEM block receiver: directed framing cases plus random traffic.
module xmodem_block_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import xbr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          RANDOM_BYTES  = 950;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] number;
    logic       is_big;
  } line_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       line_error = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] kind;
  logic [7:0] payload_byte;
  logic [7:0] block_number;
  logic       large_block;

  // Parser state as the block should hold it
  logic        use_crc = 1'b1;
  logic [10:0] frame_pos = '0;
  logic        frame_big = 1'b0;
  logic [7:0]  frame_seq = 8'h00;
  logic [7:0]  frame_comp = 8'h00;
  logic [7:0]  frame_sum = 8'h00;
  logic [15:0] frame_crc = 16'h0000;
  logic [7:0]  frame_trail = 8'h00;
  logic        can_pending = 1'b0;
  logic [7:0]  next_block = 8'd1;

  line_event_t block_events[$];

  int error_count = 0;
  int n_bytes = 0;
  int cycle_count = 0;
  int rcv_hold = 0;
  int kind_count [7] = '{default: 0};
  bit jitter_on = 1'b1;

  xmodem_block_receiver i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .line_error   (line_error),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .block_number (block_number),
    .large_block  (large_block)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Bit-serial form of the 0x1021 update, MSB first
  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic kind_t classify_block(bit trailer_ok);
    kind_t k;
    if (frame_seq != ~frame_comp || !trailer_ok) begin
      k = KIND_BAD;
    end else if (frame_seq == next_block) begin
      k = KIND_NEW;
      next_block = next_block + 8'd1;
    end else if (frame_seq == next_block - 8'd1) begin
      k = KIND_DUPLICATE;
    end else begin
      k = KIND_OUT_OF_SEQ;
    end
    frame_pos = '0;
    can_pending = 1'b0;
    return k;
  endfunction

  function automatic void parse_line_byte(logic [7:0] b, logic err);
    int unsigned blen;
    line_event_t ev;
    ev = '{kind: KIND_PAYLOAD, data: 8'h00, number: 8'h00, is_big: 1'b0};
    if (err) frame_pos = '0;
    blen = frame_big ? LARGE_LEN : SMALL_LEN;
    if (frame_pos == 0) begin
      if (b == SOH_BYTE || b == STX_BYTE) begin
        frame_big = (b == STX_BYTE);
        frame_sum = 8'h00;
        frame_crc = 16'h0000;
        frame_pos = 11'd1;
      end else if (b == EOT_BYTE) begin
        ev.kind = KIND_EOT;
        block_events.push_back(ev);
      end else if (b == CAN_BYTE) begin
        if (can_pending) begin
          ev.kind = KIND_CANCEL;
          block_events.push_back(ev);
        end else begin
          can_pending = 1'b1;
        end
      end else begin
        can_pending = 1'b0;
      end
    end else if (frame_pos == 1) begin
      frame_seq = b;
      frame_pos = 11'd2;
    end else if (frame_pos == 2) begin
      frame_comp = b;
      frame_pos = 11'd3;
    end else if (frame_pos < blen + 3) begin
      frame_sum = frame_sum + b;
      frame_crc = crc16_step(frame_crc, b);
      frame_pos = frame_pos + 11'd1;
      ev.data = b;
      ev.is_big = frame_big;
      block_events.push_back(ev);
    end else if (frame_pos == blen + 3 && !use_crc) begin
      ev.kind = classify_block(b == frame_sum);
      ev.number = frame_seq;
      ev.is_big = frame_big;
      block_events.push_back(ev);
    end else if (frame_pos == blen + 3) begin
      frame_trail = b;
      frame_pos = frame_pos + 11'd1;
    end else begin
      // second trailer byte always closes with the CRC compare
      ev.kind = classify_block(frame_trail == frame_crc[15:8] && b == frame_crc[7:0]);
      ev.number = frame_seq;
      ev.is_big = frame_big;
      block_events.push_back(ev);
    end
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : result_check
    line_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (block_events.size() == 0) begin
        report_mismatch($sformatf("result kind %0d with nothing pending", kind));
      end else begin
        want = block_events.pop_front();
        if (kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
        if (payload_byte !== want.data)
          report_mismatch($sformatf("payload_byte %02h, want %02h", payload_byte, want.data));
        if (block_number !== want.number)
          report_mismatch($sformatf("block_number %02h, want %02h", block_number, want.number));
        if (large_block !== want.is_big)
          report_mismatch($sformatf("large_block %0b, want %0b", large_block, want.is_big));
        kind_count[int'(want.kind)]++;
      end
      rcv_hold = jitter_on ? $urandom_range(0, 4) : 0;
    end
  end

  // Receiver back-pressure, drawn per result transaction
  always @(negedge clk) begin
    if (rcv_hold > 0) begin
      out_ready <= 1'b0;
      rcv_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             block_events.size());
    $display("tb: failure");
    $finish;
  end

  // Entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic err);
    int gap;
    gap = jitter_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    line_error <= err;
    do @(posedge clk); while (!in_ready);
    parse_line_byte(b, err);
    n_bytes++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (block_events.size() != 0) @(negedge clk);
    // bytes with no result may still sit in the pipeline
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_trailer_mode(input bit crc);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= crc;
    do @(posedge clk); while (!cfg_ready);
    use_crc = crc;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] payload_at(int i);
    case (i)
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return SOH_BYTE;
      3:       return STX_BYTE;
      4:       return EOT_BYTE;
      5, 6:    return CAN_BYTE;
      7:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Header, sequence pair and count payload bytes; header carries a line error
  // when hdr_err is set or the parser is mid-block, so the block always starts clean.
  task automatic send_frame_body(input bit big, input logic [7:0] num, input bit comp_ok,
                                 input int unsigned count, input bit hdr_err,
                                 output logic [7:0] s, output logic [15:0] c);
    logic [7:0] b;
    logic [7:0] comp;
    s = 8'h00;
    c = 16'h0000;
    comp = ~num;
    if (!comp_ok) comp = comp ^ 8'($urandom_range(1, 255));
    send_byte(big ? STX_BYTE : SOH_BYTE, hdr_err || frame_pos != 0);
    send_byte(num, 1'b0);
    send_byte(comp, 1'b0);
    for (int i = 0; i < count; i++) begin
      b = payload_at(i);
      s = s + b;
      c = crc16_step(c, b);
      send_byte(b, 1'b0);
    end
  endtask

  task automatic send_trailer(input logic [7:0] s, input logic [15:0] c, input bit ok);
    logic [7:0] flip;
    flip = ok ? 8'h00 : 8'($urandom_range(1, 255));
    if (use_crc) begin
      if ($urandom_range(0, 1) == 1) begin
        send_byte(c[15:8] ^ flip, 1'b0);
        send_byte(c[7:0], 1'b0);
      end else begin
        send_byte(c[15:8], 1'b0);
        send_byte(c[7:0] ^ flip, 1'b0);
      end
    end else begin
      send_byte(s ^ flip, 1'b0);
    end
  endtask

  task automatic send_frame(input bit big, input logic [7:0] num, input bit comp_ok,
                            input bit trailer_ok);
    logic [7:0]  s;
    logic [15:0] c;
    send_frame_body(big, num, comp_ok, big ? LARGE_LEN : SMALL_LEN, 1'b0, s, c);
    send_trailer(s, c, trailer_ok);
  endtask

  task automatic test_control_bytes();
    send_byte(EOT_BYTE, 1'b0);
    send_byte(CAN_BYTE, 1'b0);
    send_byte(8'h41, 1'b0);      // breaks the CAN pair
    send_byte(CAN_BYTE, 1'b0);
    send_byte(CAN_BYTE, 1'b0);   // cancel
    send_byte(CAN_BYTE, 1'b0);   // still armed: cancel again
    send_byte(EOT_BYTE, 1'b0);   // EOT keeps the CAN memory
    send_byte(CAN_BYTE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CAN_BYTE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CAN_BYTE, 1'b0);
    send_byte(CAN_BYTE, 1'b1);   // line error keeps the CAN memory
    send_byte(8'h7E, 1'b1);
    send_byte(EOT_BYTE, 1'b1);
    settle();
  endtask

  task automatic test_small_blocks_crc();
    set_trailer_mode(1'b1);
    send_frame(1'b0, next_block, 1'b1, 1'b1);
    send_frame(1'b0, next_block - 8'd1, 1'b1, 1'b1);
    send_frame(1'b0, 8'h00, 1'b1, 1'b1);
    send_frame(1'b0, 8'hFF, 1'b1, 1'b1);
    send_frame(1'b0, next_block, 1'b0, 1'b1);
    send_frame(1'b0, next_block, 1'b1, 1'b0);
    send_frame(1'b0, next_block, 1'b0, 1'b0);
    // a verdict clears the CAN memory
    send_byte(CAN_BYTE, 1'b0);
    send_frame(1'b0, next_block, 1'b1, 1'b1);
    send_byte(CAN_BYTE, 1'b0);
    send_byte(8'h55, 1'b0);
    settle();
  endtask

  task automatic test_checksum_mode();
    set_trailer_mode(1'b0);
    send_frame(1'b0, next_block, 1'b1, 1'b1);
    send_frame(1'b0, next_block, 1'b1, 1'b0);
    send_frame(1'b0, next_block - 8'd1, 1'b1, 1'b1);
    send_frame(1'b0, next_block + 8'd3, 1'b1, 1'b1);
    send_frame(1'b0, next_block, 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_large_blocks();
    set_trailer_mode(1'b1);
    send_frame(1'b1, next_block, 1'b1, 1'b1);
    send_frame(1'b1, next_block, 1'b1, 1'b0);
    set_trailer_mode(1'b0);
    send_frame(1'b1, next_block, 1'b1, 1'b1);
    send_frame(1'b1, next_block - 8'd1, 1'b1, 1'b1);
    settle();
  endtask

  task automatic test_line_error();
    logic [7:0]  s;
    logic [15:0] c;
    set_trailer_mode(1'b1);
    // restart in the middle of the payload
    send_frame_body(1'b0, next_block, 1'b1, 10, 1'b0, s, c);
    send_frame(1'b0, next_block, 1'b1, 1'b1);
    // error on the trailer turns the byte into an idle-state EOT
    send_frame_body(1'b0, next_block, 1'b1, SMALL_LEN, 1'b0, s, c);
    send_byte(c[15:8], 1'b0);
    send_byte(EOT_BYTE, 1'b1);
    // error on the sequence byte
    send_byte(SOH_BYTE, 1'b0);
    send_byte(EOT_BYTE, 1'b1);
    // a header leaves the CAN memory alone
    send_byte(CAN_BYTE, 1'b0);
    send_byte(SOH_BYTE, 1'b0);
    send_byte(next_block, 1'b0);
    send_byte(CAN_BYTE, 1'b1);
    send_byte(8'h20, 1'b1);
    settle();
  endtask

  task automatic test_mode_switch_mid_block();
    logic [7:0]  s;
    logic [15:0] c;
    set_trailer_mode(1'b1);
    send_frame_body(1'b0, next_block, 1'b1, SMALL_LEN, 1'b0, s, c);
    set_trailer_mode(1'b0);
    send_trailer(s, c, 1'b1);
    send_frame_body(1'b0, next_block, 1'b1, SMALL_LEN, 1'b0, s, c);
    set_trailer_mode(1'b1);
    send_trailer(s, c, 1'b1);
    // mode dropped after the first CRC byte: the CRC compare still decides
    send_frame_body(1'b0, next_block, 1'b1, SMALL_LEN, 1'b0, s, c);
    send_byte(c[15:8], 1'b0);
    set_trailer_mode(1'b0);
    send_byte(c[7:0], 1'b0);
    settle();
  endtask

  // Walk the block counter through 255 and back to 0
  task automatic test_sequence_wrap();
    set_trailer_mode(1'b0);
    jitter_on = 1'b0;
    while (next_block != 8'hFF) send_frame(1'b0, next_block, 1'b1, 1'b1);
    send_frame(1'b0, 8'hFF, 1'b1, 1'b1);
    send_frame(1'b0, 8'hFF, 1'b1, 1'b1);
    send_frame(1'b0, 8'h00, 1'b1, 1'b1);
    send_frame(1'b0, 8'h00, 1'b1, 1'b1);
    settle();
    jitter_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int          start_count;
    int          pick;
    int          burst;
    int unsigned blen;
    int unsigned count;
    bit          big;
    bit          comp_ok;
    bit          trailer_ok;
    logic [7:0]  num;
    logic [7:0]  b;
    logic [7:0]  s;
    logic [15:0] c;
    start_count = n_bytes;
    while (n_bytes - start_count < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) jitter_on = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        big = ($urandom_range(0, 15) == 0);
        blen = big ? LARGE_LEN : SMALL_LEN;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: num = next_block;
          6, 7:             num = next_block - 8'd1;
          default:          num = 8'($urandom_range(0, 255));
        endcase
        comp_ok = ($urandom_range(0, 9) != 0);
        trailer_ok = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 11) == 0) begin
          count = $urandom_range(0, blen - 1);
          send_frame_body(big, num, comp_ok, count, $urandom_range(0, 7) == 0, s, c);
          send_byte(8'($urandom_range(0, 255)), 1'b1);
        end else begin
          send_frame_body(big, num, comp_ok, blen, $urandom_range(0, 7) == 0, s, c);
          send_trailer(s, c, trailer_ok);
        end
      end else if (pick < 70) begin
        set_trailer_mode(1'($urandom_range(0, 1)));
      end else begin
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          case ($urandom_range(0, 11))
            0, 1, 2: b = CAN_BYTE;
            3:       b = EOT_BYTE;
            4:       b = SOH_BYTE;
            5:       b = STX_BYTE;
            default: b = 8'($urandom_range(0, 255));
          endcase
          send_byte(b, $urandom_range(0, 7) == 0);
        end
      end
    end
    jitter_on = 1'b1;
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_control_bytes();
    test_small_blocks_crc();
    test_checksum_mode();
    test_large_blocks();
    test_line_error();
    test_mode_switch_mid_block();
    test_sequence_wrap();
    test_random_traffic();
    settle();
    $display("covered %0d line bytes: %0d payload, %0d new, %0d duplicate, %0d out of sequence",
             n_bytes, kind_count[KIND_PAYLOAD], kind_count[KIND_NEW],
             kind_count[KIND_DUPLICATE], kind_count[KIND_OUT_OF_SEQ]);
    $display("%0d bad blocks, %0d EOT, %0d cancel; both trailer modes, 128 and 1024 byte blocks",
             kind_count[KIND_BAD], kind_count[KIND_EOT], kind_count[KIND_CANCEL]);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- xmodem_block_receiver.f -----
hw/rtl/xbr_pkg.sv
hw/rtl/xbr_front.sv
hw/rtl/xbr_queue.sv
hw/rtl/xbr_back.sv
hw/rtl/xmodem_block_receiver.sv
verif/xmodem_block_receiver_test.sv
